@@ design/kmld_pkg.sv @@
// ============================================================================
// kmld_pkg - shared definitions for the key matrix lockout debounce block
// Matrix size, register map, per-key phase codes, map ROM and bus structs.
// ============================================================================
package kmld_pkg;

  // Matrix geometry
  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 4;
  localparam int KEY_TOTAL    = ROW_COUNT * COLUMN_COUNT;
  localparam int KEY_W        = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;

  // Item field widths
  localparam int ROW_W     = 2;
  localparam int COL_W     = 2;
  localparam int BUTTON_W  = 4;
  localparam int LOCKOUT_W = 16;
  localparam int COUNT_W   = 5;

  // Register map: word index of each register
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_LOCKOUT_LEN  = 2'd0;
  localparam logic [1:0] REG_BUTTONS_ZERO = 2'd1;
  localparam logic [1:0] REG_BUTTONS_ONE  = 2'd2;

  // Register reset values
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET      = 16'd100;
  localparam logic [COUNT_W-1:0]   BUTTONS_ZERO_RESET = 5'd4;
  localparam logic [COUNT_W-1:0]   BUTTONS_ONE_RESET  = 5'd12;

  // Per-key debounce phase
  typedef enum logic [3:0] {
    PH_WAIT_PRESS      = 4'b0001,
    PH_PRESS_LOCKOUT   = 4'b0010,
    PH_WAIT_RELEASE    = 4'b0100,
    PH_RELEASE_LOCKOUT = 4'b1000
  } phase_e;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [LOCKOUT_W-1:0] lockout_len;
    logic [COUNT_W-1:0]   buttons_zero;
    logic [COUNT_W-1:0]   buttons_one;
  } cfg_t;

  // Key update request into the key state file
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] idx;
    logic             down;
  } key_req_t;

  // Event decision out of the key state file
  typedef struct packed {
    logic event_hit;
    logic press;
  } key_evt_t;

  // Map ROM: stick of a column (column 3 is stick 0)
  function automatic logic map_stick(input logic [COL_W-1:0] col);
    logic stick;
    stick = (col != 2'd3);
    return stick;
  endfunction

  // Map ROM: button of a column/row pair
  function automatic logic [BUTTON_W-1:0] map_button(input logic [COL_W-1:0] col,
                                                     input logic [ROW_W-1:0] row);
    logic [BUTTON_W-1:0] button;
    if (col == 2'd3) begin
      button = {2'b00, row};
    end else begin
      button = {col, row};
    end
    return button;
  endfunction

endpackage

@@ design/kmld_cfg.sv @@
// ============================================================================
// kmld_cfg - configuration registers
// APB-style register port holding the lockout length and button counts.
// ============================================================================
module kmld_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kmld_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output kmld_pkg::cfg_t            cfg_o
);

  kmld_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        kmld_pkg::REG_LOCKOUT_LEN:  cfg_d.lockout_len  = pwdata[kmld_pkg::LOCKOUT_W-1:0];
        kmld_pkg::REG_BUTTONS_ZERO: cfg_d.buttons_zero = pwdata[kmld_pkg::COUNT_W-1:0];
        kmld_pkg::REG_BUTTONS_ONE:  cfg_d.buttons_one  = pwdata[kmld_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_len  <= kmld_pkg::LOCKOUT_RESET;
      cfg_q.buttons_zero <= kmld_pkg::BUTTONS_ZERO_RESET;
      cfg_q.buttons_one  <= kmld_pkg::BUTTONS_ONE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read mux
  always_comb begin
    case (reg_idx)
      kmld_pkg::REG_LOCKOUT_LEN:  prdata = {16'd0, cfg_q.lockout_len};
      kmld_pkg::REG_BUTTONS_ZERO: prdata = {27'd0, cfg_q.buttons_zero};
      kmld_pkg::REG_BUTTONS_ONE:  prdata = {27'd0, cfg_q.buttons_one};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/kmld_key_file.sv @@
// ============================================================================
// kmld_key_file - per-key debounce state
// Phase and lockout counter of every key, with the read-modify-write step.
// ============================================================================
module kmld_key_file (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kmld_pkg::key_req_t                 req_i,
  input  logic [kmld_pkg::LOCKOUT_W-1:0]     lockout_len_i,
  output kmld_pkg::key_evt_t                 evt_o
);

  kmld_pkg::phase_e                   phase_q [kmld_pkg::KEY_TOTAL];
  logic [kmld_pkg::LOCKOUT_W-1:0]     left_q  [kmld_pkg::KEY_TOTAL];
  kmld_pkg::phase_e                   cur_phase, phase_d;
  logic [kmld_pkg::LOCKOUT_W-1:0]     cur_left, left_d;
  logic                               timeout;
  logic                               hit;
  logic                               press;

  assign cur_phase = phase_q[req_i.idx];
  assign cur_left  = left_q[req_i.idx];
  assign timeout   = (cur_left == kmld_pkg::LOCKOUT_W'(1));

  // Phase transition and event detect for the addressed key
  always_comb begin
    phase_d = cur_phase;
    hit     = 1'b0;
    press   = 1'b0;
    case (cur_phase)
      kmld_pkg::PH_WAIT_PRESS: begin
        if (req_i.down) begin
          hit     = 1'b1;
          press   = 1'b1;
          phase_d = kmld_pkg::PH_PRESS_LOCKOUT;
        end
      end
      kmld_pkg::PH_PRESS_LOCKOUT: begin
        if (timeout) phase_d = kmld_pkg::PH_WAIT_RELEASE;
      end
      kmld_pkg::PH_WAIT_RELEASE: begin
        if (!req_i.down) begin
          hit     = 1'b1;
          phase_d = kmld_pkg::PH_RELEASE_LOCKOUT;
        end
      end
      kmld_pkg::PH_RELEASE_LOCKOUT: begin
        if (timeout) phase_d = kmld_pkg::PH_WAIT_PRESS;
      end
      default: phase_d = kmld_pkg::PH_WAIT_PRESS;
    endcase
  end

  // Lockout counter: reload on an event, else count down to zero
  always_comb begin
    if (hit) begin
      left_d = lockout_len_i;
    end else if (cur_left != '0) begin
      left_d = cur_left - kmld_pkg::LOCKOUT_W'(1);
    end else begin
      left_d = cur_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kmld_pkg::KEY_TOTAL; i++) begin
        phase_q[i] <= kmld_pkg::PH_WAIT_PRESS;
        left_q[i]  <= '0;
      end
    end else if (req_i.valid) begin
      phase_q[req_i.idx] <= phase_d;
      left_q[req_i.idx]  <= left_d;
    end
  end

  assign evt_o.event_hit = hit;
  assign evt_o.press     = press;

endmodule

@@ design/key_matrix_lockout_debounce_top.sv @@
// ============================================================================
// key_matrix_lockout_debounce_top - scanned key matrix debouncer
// Turns key scan samples into press/release events with lockout per key.
// ============================================================================
// Usage:
//   Slave stream: one scan sample per item (row, column, contact closed).
//   Master stream: one event item (stick, button, press/release) for each
//   sample that starts a press or a release on a key whose button is below
//   its stick's button count; other samples yield no item.
//   APB port: lockout length and the two button counts, written while the
//   block is idle.
// Timing:
//   An item is registered on acceptance and evaluated when the output
//   register is free or drained: the per-key state is read, updated and
//   the event lands in the output register; one item per cycle, set by the
//   single read-modify-write of the per-key state file, while tready is high.
// Reset:
//   All keys wait for a press with counters at zero; registers take their
//   default values (100 scans, 4 and 12 buttons).
// Stall:
//   While an event waits in the output register and the receiver holds
//   tready low, the evaluation stage holds; an empty input register takes
//   one more sample, then s_axis_tready drops.
// ============================================================================
module key_matrix_lockout_debounce_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Scan samples
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [1:0] key_row, [3:2] key_column,
                                                     // [4] key_down
  // Key events
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [0] stick_number,
                                                     // [4:1] button_number, [5] is_press
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kmld_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  kmld_pkg::cfg_t                  cfg;
  kmld_pkg::key_req_t              req;
  kmld_pkg::key_evt_t              evt;

  logic                            in_valid_q;
  logic [kmld_pkg::ROW_W-1:0]      in_row_q;
  logic [kmld_pkg::COL_W-1:0]      in_col_q;
  logic                            in_down_q;

  logic                            out_valid_q, out_valid_d;
  logic                            out_stick_q, out_stick_d;
  logic [kmld_pkg::BUTTON_W-1:0]   out_button_q, out_button_d;
  logic                            out_press_q, out_press_d;

  logic                            advance;
  logic                            in_range;
  logic                            stick;
  logic [kmld_pkg::BUTTON_W-1:0]   button;
  logic [kmld_pkg::COUNT_W-1:0]    count;
  logic                            pass;

  kmld_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Evaluation stage moves when the output register is free or drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_row_q  <= s_axis_tdata[1:0];
      in_col_q  <= s_axis_tdata[3:2];
      in_down_q <= s_axis_tdata[4];
    end
  end

  // Keys outside the matrix are dropped
  assign in_range = (int'(in_row_q) < kmld_pkg::ROW_COUNT) &&
                    (int'(in_col_q) < kmld_pkg::COLUMN_COUNT);

  assign req.valid = in_valid_q && advance && in_range;
  assign req.idx   = kmld_pkg::KEY_W'(int'(in_row_q) * kmld_pkg::COLUMN_COUNT + int'(in_col_q));
  assign req.down  = in_down_q;

  kmld_key_file u_key_file (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .lockout_len_i (cfg.lockout_len),
    .evt_o         (evt)
  );

  // Map ROM lookup and button count filter
  assign stick  = kmld_pkg::map_stick(in_col_q);
  assign button = kmld_pkg::map_button(in_col_q, in_row_q);
  assign count  = stick ? cfg.buttons_one : cfg.buttons_zero;
  assign pass   = ({1'b0, button} < count);

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_stick_d  = out_stick_q;
    out_button_d = out_button_q;
    out_press_d  = out_press_q;
    if (advance) begin
      out_valid_d  = req.valid && evt.event_hit && pass;
      out_stick_d  = stick;
      out_button_d = button;
      out_press_d  = evt.press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_stick_q  <= out_stick_d;
    out_button_q <= out_button_d;
    out_press_q  <= out_press_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_press_q, out_button_q, out_stick_q};

  // An accepted sample always occupies the input register next cycle
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_valid_q)
    else $error("accepted sample not held in input register");

  // Back-pressure only with a full input register
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q)
    else $error("input stalled without a pending item");

  // A delivered event always passes the stick's button count
  a_event_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, out_button_q} <
                       (out_stick_q ? cfg.buttons_one : cfg.buttons_zero)))
    else $error("suppressed button reached the output");

endmodule

@@ bench/key_matrix_lockout_debounce_top_tb.sv @@
// ============================================================================
// key_matrix_lockout_debounce_top_tb - self-checking bench for the debouncer
// Drives key scan samples into the slave stream and tracks per-key debounce
// state in a local predictor. Each event on the master stream is checked
// field by field against the oldest expected event. The registers are
// written and read back between phases. Both sides idle at random, and the
// receiver holds off long enough to stall the input once.
// ============================================================================
module key_matrix_lockout_debounce_top_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int DIR_ROWS    = 22;
  localparam int DIR_SPLIT   = 10;

  // One key event as seen on the master stream
  typedef struct packed {
    logic                          stick;
    logic [kmld_pkg::BUTTON_W-1:0] button;
    logic                          press;
  } key_event_t;

  // One directed scan; typed rows carry their own expected event
  typedef struct packed {
    logic [kmld_pkg::ROW_W-1:0]    row;
    logic [kmld_pkg::COL_W-1:0]    col;
    logic                          down;
    logic                          typed;
    logic                          hit;
    logic                          stick;
    logic [kmld_pkg::BUTTON_W-1:0] button;
    logic                          press;
  } scan_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [1:0] key_row, [3:2] key_column, [4] key_down
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] stick_number, [4:1] button_number, [5] is_press
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [kmld_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and its copy of the registers
  kmld_pkg::phase_e               key_phase_m [kmld_pkg::KEY_TOTAL];
  logic [kmld_pkg::LOCKOUT_W-1:0] lock_left_m [kmld_pkg::KEY_TOTAL];
  logic [kmld_pkg::LOCKOUT_W-1:0] lockout_len;
  logic [kmld_pkg::COUNT_W-1:0]   btn_count_zero;
  logic [kmld_pkg::COUNT_W-1:0]   btn_count_one;

  key_event_t pending_events [$];
  logic       key_level [kmld_pkg::KEY_TOTAL];
  int         error_count = 0;
  int         stall_cycles = 0;
  int         rx_hold_len = 0;
  bit         tx_gaps_on = 1'b0;
  bit         rx_gaps_on = 1'b0;

  // Directed scans: reset settings first, then a lockout of one scan
  scan_row_t dir_table [DIR_ROWS] = '{
    '{2'd0, 2'd3, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0,  1'b1},
    '{2'd0, 2'd3, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd0, 2'd3, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd3, 2'd3, 1'b1, 1'b1, 1'b1, 1'b0, 4'd3,  1'b1},
    '{2'd3, 2'd2, 1'b1, 1'b1, 1'b1, 1'b1, 4'd11, 1'b1},
    '{2'd0, 2'd0, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0,  1'b1},
    '{2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd1, 2'd2, 1'b1, 1'b1, 1'b1, 1'b1, 4'd9,  1'b1},
    '{2'd3, 2'd0, 1'b1, 1'b1, 1'b1, 1'b1, 4'd3,  1'b1},
    '{2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd1, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd3, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{2'd2, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  1'b0}
  };

  key_matrix_lockout_debounce_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Debounce predictor: updates one key, returns 1 when an event goes out
  function automatic logic debounce_predict(input logic [kmld_pkg::ROW_W-1:0] row,
                                            input logic [kmld_pkg::COL_W-1:0] col,
                                            input logic dn,
                                            output key_event_t ev);
    int unsigned                    k;
    kmld_pkg::phase_e               ph;
    logic [kmld_pkg::LOCKOUT_W-1:0] left;
    logic                           expired;
    logic                           fired;
    logic [kmld_pkg::COUNT_W-1:0]   present;
    ev = '0;
    // keys outside the matrix are ignored without a state change
    if (row >= kmld_pkg::ROW_COUNT || col >= kmld_pkg::COLUMN_COUNT) begin
      return 1'b0;
    end
    k       = row * kmld_pkg::COLUMN_COUNT + col;
    ph      = key_phase_m[k];
    left    = lock_left_m[k];
    expired = (left == 1);
    fired   = 1'b0;
    case (ph)
      kmld_pkg::PH_WAIT_PRESS: begin
        if (dn) begin
          fired    = 1'b1;
          ev.press = 1'b1;
          ph       = kmld_pkg::PH_PRESS_LOCKOUT;
        end
      end
      kmld_pkg::PH_PRESS_LOCKOUT: begin
        if (expired) ph = kmld_pkg::PH_WAIT_RELEASE;
      end
      kmld_pkg::PH_WAIT_RELEASE: begin
        if (!dn) begin
          fired = 1'b1;
          ph    = kmld_pkg::PH_RELEASE_LOCKOUT;
        end
      end
      default: begin
        if (expired) ph = kmld_pkg::PH_WAIT_PRESS;
      end
    endcase
    if (fired) left = lockout_len;
    else if (left != 0) left = left - 1'b1;
    key_phase_m[k] = ph;
    lock_left_m[k] = left;
    if (!fired) begin
      return 1'b0;
    end
    // map ROM: column 3 is stick 0 with button = row, others stick 1
    ev.stick  = (col != 2'd3);
    ev.button = (col == 2'd3) ? kmld_pkg::BUTTON_W'(row)
                              : kmld_pkg::BUTTON_W'(col * 4 + row);
    present   = ev.stick ? btn_count_one : btn_count_zero;
    // suppressed when the button is not below the stick's count
    return ({1'b0, ev.button} < present);
  endfunction

  // Offer one scan sample, with an optional random gap first
  task automatic send_scan(input logic [kmld_pkg::ROW_W-1:0] row,
                           input logic [kmld_pkg::COL_W-1:0] col,
                           input logic dn);
    if (tx_gaps_on && $urandom_range(7, 0) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, dn, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Send one sample and queue whatever the predictor expects from it
  task automatic scan_checked(input logic [kmld_pkg::ROW_W-1:0] row,
                              input logic [kmld_pkg::COL_W-1:0] col,
                              input logic dn);
    key_event_t ev;
    logic       hit;
    send_scan(row, col, dn);
    hit = debounce_predict(row, col, dn, ev);
    if (hit) pending_events.push_back(ev);
  endtask

  // Random scans over keys k_lo..k_hi: each key follows a held level that
  // flips now and then, with occasional contact bounce on top
  task automatic run_scans(input int n, input int k_lo, input int k_hi);
    int   k;
    logic dn;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(k_hi, k_lo);
      if ($urandom_range(3, 0) == 0) key_level[k] = ~key_level[k];
      dn = key_level[k];
      if ($urandom_range(9, 0) == 0) dn = ~dn;
      scan_checked(kmld_pkg::ROW_W'(k / kmld_pkg::COLUMN_COUNT),
                   kmld_pkg::COL_W'(k % kmld_pkg::COLUMN_COUNT), dn);
    end
  endtask

  // Stop sending and wait until every expected event has come out
  task automatic drain_events(input int tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Expected register contents, masked to each register's width
  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      kmld_pkg::REG_LOCKOUT_LEN:  return 32'(lockout_len);
      kmld_pkg::REG_BUTTONS_ZERO: return 32'(btn_count_zero);
      default:                    return 32'(btn_count_one);
    endcase
  endfunction

  // APB read with compare
  task automatic cfg_read(input logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== reg_value(idx)) begin
      $error("prdata reg %0d: expected %0h, actual %0h", idx, reg_value(idx), prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // APB write, then read back in the following transfer
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      kmld_pkg::REG_LOCKOUT_LEN:  lockout_len    = value[kmld_pkg::LOCKOUT_W-1:0];
      kmld_pkg::REG_BUTTONS_ZERO: btn_count_zero = value[kmld_pkg::COUNT_W-1:0];
      default:                    btn_count_one  = value[kmld_pkg::COUNT_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== reg_value(idx)) begin
      $error("prdata reg %0d: expected %0h, actual %0h", idx, reg_value(idx), prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random ready bursts, plus long hold-offs on request
  initial begin : event_sink
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
        m_axis_tready <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(5, 0) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(9, 1)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Event checker
  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: tdata %0h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata[0] !== want.stick) begin
          $error("stick_number: expected %0d, actual %0d", want.stick, m_axis_tdata[0]);
          error_count++;
        end
        if (m_axis_tdata[4:1] !== want.button) begin
          $error("button_number: expected %0d, actual %0d", want.button, m_axis_tdata[4:1]);
          error_count++;
        end
        if (m_axis_tdata[5] !== want.press) begin
          $error("is_press: expected %0d, actual %0d", want.press, m_axis_tdata[5]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus
  initial begin : stimulus
    key_event_t ev;
    logic       hit;
    scan_row_t  r;
    lockout_len    = kmld_pkg::LOCKOUT_RESET;
    btn_count_zero = kmld_pkg::BUTTONS_ZERO_RESET;
    btn_count_one  = kmld_pkg::BUTTONS_ONE_RESET;
    for (int k = 0; k < kmld_pkg::KEY_TOTAL; k++) begin
      key_phase_m[k] = kmld_pkg::PH_WAIT_PRESS;
      lock_left_m[k] = '0;
      key_level[k]   = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers
    cfg_read(kmld_pkg::REG_LOCKOUT_LEN);
    cfg_read(kmld_pkg::REG_BUTTONS_ZERO);
    cfg_read(kmld_pkg::REG_BUTTONS_ONE);

    // directed scans, the second part with a one-scan lockout
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      r = dir_table[i];
      if (i == DIR_SPLIT) begin
        drain_events(4);
        cfg_write(kmld_pkg::REG_LOCKOUT_LEN, 32'd1);
      end
      send_scan(r.row, r.col, r.down);
      hit = debounce_predict(r.row, r.col, r.down, ev);
      if (r.typed) begin
        if (r.hit) pending_events.push_back(key_event_t'{r.stick, r.button, r.press});
      end else if (hit) begin
        pending_events.push_back(ev);
      end
    end

    // all buttons enabled, shortest lockout, with back-pressure
    drain_events(4);
    cfg_write(kmld_pkg::REG_BUTTONS_ZERO, 32'd16);
    cfg_write(kmld_pkg::REG_BUTTONS_ONE, 32'd16);
    run_scans(100, 0, kmld_pkg::KEY_TOTAL - 1);
    rx_hold_len = HOLD_CYCLES;
    run_scans(100, 0, kmld_pkg::KEY_TOTAL - 1);
    drain_events(0);
    run_scans(100, 0, kmld_pkg::KEY_TOTAL - 1);

    // every event suppressed
    drain_events(4);
    tx_gaps_on = 1'b0;
    cfg_write(kmld_pkg::REG_LOCKOUT_LEN, 32'd2);
    cfg_write(kmld_pkg::REG_BUTTONS_ZERO, 32'd0);
    cfg_write(kmld_pkg::REG_BUTTONS_ONE, 32'd0);
    run_scans(80, 0, kmld_pkg::KEY_TOTAL - 1);

    // partial suppression on both sticks
    drain_events(4);
    tx_gaps_on = 1'b1;
    cfg_write(kmld_pkg::REG_LOCKOUT_LEN, 32'($urandom_range(4, 1)));
    cfg_write(kmld_pkg::REG_BUTTONS_ZERO, 32'd2);
    cfg_write(kmld_pkg::REG_BUTTONS_ONE, 32'd7);
    run_scans(250, 0, kmld_pkg::KEY_TOTAL - 1);

    // out-of-range counts let all buttons through; no idling from here on
    drain_events(4);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    cfg_write(kmld_pkg::REG_LOCKOUT_LEN, 32'd3);
    cfg_write(kmld_pkg::REG_BUTTONS_ZERO, 32'd31);
    cfg_write(kmld_pkg::REG_BUTTONS_ONE, 32'd31);
    run_scans(300, 0, kmld_pkg::KEY_TOTAL - 1);

    // longest lockout, on one key only since it stays locked afterwards
    drain_events(4);
    cfg_write(kmld_pkg::REG_LOCKOUT_LEN, 32'd65535);
    run_scans(12, 0, 0);

    // zero lockout: the next event parks its key in lockout for good
    drain_events(4);
    cfg_write(kmld_pkg::REG_LOCKOUT_LEN, 32'd0);
    run_scans(20, 1, 1);

    drain_events(8);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
